// ===== sv/dsdc_pkg.sv =====
// Shared types, constants and the 32-bit CRC byte update for the sector deframe checker.
// Used by every module of the block; has no dependencies of its own.
package dsdc_pkg;

  localparam int ADDR_BYTES    = 9;
  localparam int DATA_BYTES    = 517;
  localparam int TOTAL_BYTES   = ADDR_BYTES + DATA_BYTES;
  localparam int PAYLOAD_BYTES = DATA_BYTES - 5;
  localparam int POS_W         = $clog2(TOTAL_BYTES + 1);

  localparam logic [POS_W-1:0] POS_ADDR_LAST  = POS_W'(ADDR_BYTES - 1);
  localparam logic [POS_W-1:0] POS_DATA_FIRST = POS_W'(ADDR_BYTES);
  localparam logic [POS_W-1:0] POS_PAY_FIRST  = POS_W'(ADDR_BYTES + 1);
  localparam logic [POS_W-1:0] POS_PAY_LAST   = POS_W'(ADDR_BYTES + PAYLOAD_BYTES);
  localparam logic [POS_W-1:0] POS_LAST       = POS_W'(TOTAL_BYTES - 1);
  localparam logic [POS_W-1:0] POS_TOTAL      = POS_W'(TOTAL_BYTES);
  localparam logic [POS_W-1:0] POS_CYL_HI     = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CYL_LO     = POS_W'(2);
  localparam logic [POS_W-1:0] POS_HEAD       = POS_W'(3);
  localparam logic [POS_W-1:0] POS_SECTOR     = POS_W'(4);

  localparam logic [31:0] CRC_POLY = 32'h4104_4185;

  localparam int XQ_DEPTH = 4;
  localparam int XQ_AW    = $clog2(XQ_DEPTH);
  localparam int XQ_CW    = $clog2(XQ_DEPTH + 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADS_PER_CYL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_TRK = 2'd1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_HDR  = 2'd1,
    ST_LOC_MISS = 2'd2,
    ST_BAD_DATA = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] heads_per_cylinder;
    logic [7:0] sectors_per_track;
  } cfg_regs_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] data_byte;
    status_t    status;
    logic [15:0] cylinder;
    logic [7:0] head;
    logic [7:0] sector;
  } xq_entry_t;

  typedef struct packed {
    logic        is_status;
    logic [7:0]  out_byte;
    status_t     status;
    logic [31:0] lba;
  } result_t;

  function automatic logic [31:0] dsdc_crc_feed(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'd0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== sv/dsdc_front.sv =====
// Front end: tracks the byte position, runs the CRC and captures the address area.
// Classifies each byte and pushes data and status work into the transfer queue. Uses dsdc_pkg.
module dsdc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic                 in_sector_start,
  input  logic [7:0]           in_raw_byte,
  input  logic [15:0]          in_expected_cylinder,
  input  logic [7:0]           in_expected_head,
  input  logic                 q_full,
  output logic                 q_push,
  output dsdc_pkg::xq_entry_t  q_entry
);
  import dsdc_pkg::*;

  logic [POS_W-1:0] pos_r;
  logic [31:0]      crc_r;
  status_t          verdict_r;
  logic [15:0]      hdr_cyl_r;
  logic [7:0]       hdr_head_r;
  logic [7:0]       hdr_sector_r;
  logic [15:0]      want_cyl_r;
  logic [7:0]       want_head_r;

  logic [POS_W-1:0] pos;
  logic [31:0]      crc_base;
  logic [31:0]      crc_new;
  logic             accept;
  logic             live;
  logic             is_data;
  logic             is_last;
  status_t          final_status;

  always_comb begin
    accept       = in_push & ~q_full;
    pos          = in_sector_start ? '0 : pos_r;
    live         = pos < POS_TOTAL;
    crc_base     = (pos == '0) ? 32'd0 : crc_r;
    crc_new      = dsdc_crc_feed(crc_base, in_raw_byte);
    is_data      = (pos >= POS_PAY_FIRST) && (pos <= POS_PAY_LAST);
    is_last      = (pos == POS_LAST);
    if (verdict_r != ST_OK) begin
      final_status = verdict_r;
    end else if (crc_new != 32'd0) begin
      final_status = ST_BAD_DATA;
    end else begin
      final_status = ST_OK;
    end
    q_push              = accept && live && (is_data || is_last);
    q_entry.is_status   = is_last;
    q_entry.data_byte   = is_data ? in_raw_byte : 8'd0;
    q_entry.status      = is_last ? final_status : ST_OK;
    q_entry.cylinder    = hdr_cyl_r;
    q_entry.head        = hdr_head_r;
    q_entry.sector      = hdr_sector_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      crc_r        <= '0;
      verdict_r    <= ST_OK;
      hdr_cyl_r    <= '0;
      hdr_head_r   <= '0;
      hdr_sector_r <= '0;
      want_cyl_r   <= '0;
      want_head_r  <= '0;
    end else if (accept && live) begin
      pos_r <= pos + POS_W'(1);
      crc_r <= (pos == POS_ADDR_LAST) ? 32'd0 : crc_new;
      if (pos == '0) begin
        want_cyl_r  <= in_expected_cylinder;
        want_head_r <= in_expected_head;
        verdict_r   <= ST_OK;
      end
      if (pos == POS_CYL_HI) begin
        hdr_cyl_r[15:8] <= in_raw_byte;
      end
      if (pos == POS_CYL_LO) begin
        hdr_cyl_r[7:0] <= in_raw_byte;
      end
      if (pos == POS_HEAD) begin
        hdr_head_r <= in_raw_byte;
      end
      if (pos == POS_SECTOR) begin
        hdr_sector_r <= in_raw_byte;
      end
      if (pos == POS_ADDR_LAST) begin
        if (crc_new != 32'd0) begin
          verdict_r <= ST_BAD_HDR;
        end else if ((hdr_cyl_r != want_cyl_r) || (hdr_head_r != want_head_r)) begin
          verdict_r <= ST_LOC_MISS;
        end else begin
          verdict_r <= ST_OK;
        end
      end
    end
  end

endmodule

// ===== sv/dsdc_xfer_q.sv =====
// Short queue that decouples the front end from the back end.
// Holds transfer entries of type dsdc_pkg::xq_entry_t. Uses dsdc_pkg.
module dsdc_xfer_q (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  dsdc_pkg::xq_entry_t  push_entry,
  output logic                 full,
  input  logic                 pop,
  output dsdc_pkg::xq_entry_t  head_entry,
  output logic                 empty
);
  import dsdc_pkg::*;

  xq_entry_t        mem [XQ_DEPTH];
  logic [XQ_AW-1:0] wp_r;
  logic [XQ_AW-1:0] rp_r;
  logic [XQ_CW-1:0] cnt_r;

  assign full       = (cnt_r == XQ_CW'(XQ_DEPTH));
  assign empty      = (cnt_r == '0);
  assign head_entry = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + XQ_AW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + XQ_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + XQ_CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - XQ_CW'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("transfer queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("transfer queue read while empty");
  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + XQ_CW'(1)))
    else $error("transfer queue count did not advance");
`endif

endmodule

// ===== sv/dsdc_back.sv =====
// Back end: turns queue entries into result transactions and computes the LBA. Uses dsdc_pkg.
// The LBA passes states B_MUL1, B_MUL2 and B_SUM; results wait in a two-entry output queue.
module dsdc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dsdc_pkg::cfg_regs_t  cfg,
  input  logic                 q_empty,
  input  dsdc_pkg::xq_entry_t  q_entry,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic                 out_is_status,
  output logic [7:0]           out_byte,
  output logic [1:0]           out_status,
  output logic [31:0]          out_lba
);
  import dsdc_pkg::*;

  typedef enum logic [1:0] {
    B_RUN,
    B_MUL1,
    B_MUL2,
    B_SUM
  } bstate_t;

  bstate_t     state_r;
  logic [15:0] cyl_r;
  logic [7:0]  head_r;
  logic [7:0]  sector_r;
  logic [15:0] hs_r;
  logic [15:0] hq_r;
  logic [31:0] prod_r;

  result_t     of_mem [2];
  logic        of_wp_r;
  logic        of_rp_r;
  logic [1:0]  of_cnt_r;

  logic        of_push;
  result_t     of_data;
  logic        of_pop;
  logic [31:0] lba_sum;

  always_comb begin
    q_pop   = (state_r == B_RUN) && !q_empty && (of_cnt_r != 2'd2);
    lba_sum = prod_r + {16'd0, hq_r} + {24'd0, sector_r} - 32'd1;
    of_push = 1'b0;
    of_data = '0;
    if (q_pop) begin
      if (!q_entry.is_status) begin
        of_push           = 1'b1;
        of_data.out_byte  = q_entry.data_byte;
      end else if (q_entry.status != ST_OK) begin
        of_push           = 1'b1;
        of_data.is_status = 1'b1;
        of_data.status    = q_entry.status;
      end
    end else if (state_r == B_SUM) begin
      of_push           = 1'b1;
      of_data.is_status = 1'b1;
      of_data.status    = ST_OK;
      of_data.lba       = lba_sum;
    end
    of_pop        = out_pop && (of_cnt_r != 2'd0);
    out_empty     = (of_cnt_r == 2'd0);
    out_is_status = of_mem[of_rp_r].is_status;
    out_byte      = of_mem[of_rp_r].out_byte;
    out_status    = of_mem[of_rp_r].status;
    out_lba       = of_mem[of_rp_r].lba;
  end

  always_ff @(posedge clk) begin
    if (of_push) begin
      of_mem[of_wp_r] <= of_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_RUN;
      of_wp_r  <= 1'b0;
      of_rp_r  <= 1'b0;
      of_cnt_r <= 2'd0;
    end else begin
      case (state_r)
        B_RUN: begin
          if (q_pop && q_entry.is_status && (q_entry.status == ST_OK)) begin
            cyl_r    <= q_entry.cylinder;
            head_r   <= q_entry.head;
            sector_r <= q_entry.sector;
            state_r  <= B_MUL1;
          end
        end
        B_MUL1: begin
          hs_r    <= 16'(cfg.heads_per_cylinder) * 16'(cfg.sectors_per_track);
          hq_r    <= 16'(head_r) * 16'(cfg.sectors_per_track);
          state_r <= B_MUL2;
        end
        B_MUL2: begin
          prod_r  <= 32'(cyl_r) * 32'(hs_r);
          state_r <= B_SUM;
        end
        B_SUM: begin
          state_r <= B_RUN;
        end
        default: begin
          state_r <= B_RUN;
        end
      endcase
      if (of_push) begin
        of_wp_r <= ~of_wp_r;
      end
      if (of_pop) begin
        of_rp_r <= ~of_rp_r;
      end
      if (of_push && !of_pop) begin
        of_cnt_r <= of_cnt_r + 2'd1;
      end else if (of_pop && !of_push) begin
        of_cnt_r <= of_cnt_r - 2'd1;
      end
    end
  end

`ifndef SYNTH
  a_of_bound: assert property (@(posedge clk) disable iff (!rst_n) of_cnt_r <= 2'd2)
    else $error("output queue count out of range");
  a_mul_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_MUL1) |=> (state_r == B_MUL2))
    else $error("LBA sequence skipped the second multiply");
  a_sum_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SUM) |-> (of_cnt_r != 2'd2 || of_pop))
    else $error("LBA result pushed into a full output queue");
`endif

endmodule

// ===== sv/disk_sector_deframe_check_unit.sv =====
// Sector deframe checker: an accepted payload byte is stored in the transfer queue and then
// in the output queue; a good status also passes the LBA states B_MUL1, B_MUL2 and B_SUM.
// Throughput one byte per cycle while in_full is low; the LBA multiply is hidden by
// the transfer queue, since a sector's address area yields no results.
// Reset (rst_n low, synchronous) clears position, CRC and both queues, and loads
// 8 heads per cylinder and 32 sectors per track. Uses dsdc_pkg and the dsdc_ modules.
module disk_sector_deframe_check_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic                               in_sector_start,
  input  logic [7:0]                         in_raw_byte,
  input  logic [15:0]                        in_expected_cylinder,
  input  logic [7:0]                         in_expected_head,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic                               out_is_status,
  output logic [7:0]                         out_byte,
  output logic [1:0]                         out_status,
  output logic [31:0]                        out_lba,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dsdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                         cfg_data
);
  import dsdc_pkg::*;

  cfg_regs_t cfg_r;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  xq_entry_t q_in;
  xq_entry_t q_head;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.heads_per_cylinder <= 8'd8;
      cfg_r.sectors_per_track  <= 8'd32;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_HEADS_PER_CYL) begin
        cfg_r.heads_per_cylinder <= cfg_data;
      end else if (cfg_index == REG_SECTORS_PER_TRK) begin
        cfg_r.sectors_per_track <= cfg_data;
      end
    end
  end

  dsdc_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_sector_start      (in_sector_start),
    .in_raw_byte          (in_raw_byte),
    .in_expected_cylinder (in_expected_cylinder),
    .in_expected_head     (in_expected_head),
    .q_full               (q_full),
    .q_push               (q_push),
    .q_entry              (q_in)
  );

  dsdc_xfer_q u_xfer_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_entry (q_head),
    .empty      (q_empty)
  );

  dsdc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_empty       (q_empty),
    .q_entry       (q_head),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_is_status (out_is_status),
    .out_byte      (out_byte),
    .out_status    (out_status),
    .out_lba       (out_lba)
  );

endmodule
